/* hw/rtl/rfg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfg_pkg
// Shared types and constants of the RTP reorder buffer and FEC group former.
// ----------------------------------------------------------------------------
package rfg_pkg;

  localparam int PENDING_SLOTS = 32;
  localparam int EXT_SEQ_BITS  = 32;
  localparam int SLOT_W        = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;
  localparam int SLOT_CNT_W    = $clog2(PENDING_SLOTS + 1);

  localparam logic [15:0] LEN_LIMIT   = 16'd32767;
  localparam logic [6:0]  MAX_RESULTS = 7'd64;
  localparam logic [6:0]  RED_MAX     = 7'd127;  // largest 7-bit count

  localparam logic [1:0] KIND_PLACED  = 2'd0;
  localparam logic [1:0] KIND_CLOSED  = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;

  localparam logic [1:0] DROP_OVERSIZE = 2'd0;
  localparam logic [1:0] DROP_STREAM   = 2'd1;
  localparam logic [1:0] DROP_LATE     = 2'd2;
  localparam logic [1:0] DROP_DUP      = 2'd3;

  localparam logic [1:0] CFG_GROUP_BLOCKS = 2'd0;
  localparam logic [1:0] CFG_GROUP_RED    = 2'd1;
  localparam logic [1:0] CFG_REORDER      = 2'd2;

  typedef struct packed {
    logic [EXT_SEQ_BITS-1:0] seq;
    logic [15:0]             tag;
    logic [14:0]             len;
  } slot_entry_t;

  typedef struct packed {
    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_idx;
    slot_entry_t             wr_data;
    logic                    clr_en;
    logic [SLOT_W-1:0]       clr_idx;
    logic                    scan_start;
    logic [EXT_SEQ_BITS-1:0] scan_tgt;
  } slot_cmd_t;

  typedef struct packed {
    logic                    done;
    logic                    found;
    logic [SLOT_W-1:0]       found_idx;
    slot_entry_t             found_entry;
    logic [EXT_SEQ_BITS-1:0] min_seq;
    logic [EXT_SEQ_BITS-1:0] max_seq;
    logic                    any_valid;
    logic                    all_valid;
    logic [SLOT_W-1:0]       free_idx;
  } slot_stat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  drop_reason;
    logic [15:0] seq;
    logic [15:0] tag;
    logic [14:0] len;
    logic [6:0]  pos;
    logic [6:0]  size;
    logic [6:0]  red;
    logic [14:0] blk_len;
    logic [15:0] base_seq;
    logic        last;
  } res_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PKT, S_LATE, S_DUP, S_DROP, S_INS, S_EXP, S_AFTER_FULL,
    S_CLOSE, S_DIV, S_CLOSE_EMIT, S_EXT_DONE, S_DRAIN, S_FOUND, S_CHKFULL,
    S_FULL_EMIT, S_MAX_DONE, S_WIN, S_SCAN, S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    MODE_FLUSH, MODE_TFULL, MODE_WIN
  } mode_t;

endpackage

/* hw/rtl/rfg_slots.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfg_slots
// Pending packet store: slot memory, valid bits and a scan engine that walks
// every slot once, reporting a sequence match and the smallest and largest
// pending sequence.
// ----------------------------------------------------------------------------
module rfg_slots import rfg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  slot_cmd_t  cmd,
  output slot_stat_t stat
);

  slot_entry_t mem [PENDING_SLOTS];
  slot_entry_t rdata;

  logic [PENDING_SLOTS-1:0] slot_valid;
  logic                     active;
  logic [SLOT_CNT_W-1:0]    icnt;
  logic                     issue;
  logic                     rd_v;
  logic [SLOT_W-1:0]        rd_idx;
  logic                     have;
  logic                     done;
  logic                     found;
  logic [SLOT_W-1:0]        found_idx;
  slot_entry_t              found_entry;
  logic [EXT_SEQ_BITS-1:0]  min_seq;
  logic [EXT_SEQ_BITS-1:0]  max_seq;
  logic [EXT_SEQ_BITS-1:0]  tgt;
  logic [SLOT_W-1:0]        free_idx;

  assign issue = active && (icnt < SLOT_CNT_W'(PENDING_SLOTS));

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_idx] <= cmd.wr_data;
    end
    if (issue) begin
      rdata <= mem[icnt[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else begin
      if (cmd.clr_en) begin
        slot_valid[cmd.clr_idx] <= 1'b0;
      end
      if (cmd.wr_en) begin
        slot_valid[cmd.wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      rd_v   <= 1'b0;
      done   <= 1'b0;
      icnt   <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.scan_start) begin
        active <= 1'b1;
        icnt   <= '0;
        rd_v   <= 1'b0;
        have   <= 1'b0;
        found  <= 1'b0;
        tgt    <= cmd.scan_tgt;
      end else begin
        rd_v <= issue;
        if (issue) begin
          rd_idx <= icnt[SLOT_W-1:0];
          icnt   <= icnt + 1'b1;
        end
        if (rd_v) begin
          if (slot_valid[rd_idx]) begin
            have <= 1'b1;
            if (!have || rdata.seq < min_seq) min_seq <= rdata.seq;
            if (!have || rdata.seq > max_seq) max_seq <= rdata.seq;
            if (rdata.seq == tgt) begin
              found       <= 1'b1;
              found_idx   <= rd_idx;
              found_entry <= rdata;
            end
          end
          if (rd_idx == SLOT_W'(PENDING_SLOTS - 1)) begin
            active <= 1'b0;
            done   <= 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    free_idx = '0;
    for (int i = PENDING_SLOTS - 1; i >= 0; i--) begin
      if (!slot_valid[i]) free_idx = SLOT_W'(i);
    end
  end

  assign stat.done        = done;
  assign stat.found       = found;
  assign stat.found_idx   = found_idx;
  assign stat.found_entry = found_entry;
  assign stat.min_seq     = min_seq;
  assign stat.max_seq     = max_seq;
  assign stat.any_valid   = |slot_valid;
  assign stat.all_valid   = &slot_valid;
  assign stat.free_idx    = free_idx;

endmodule

/* hw/rtl/rtp_reorder_fec_grouper_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_reorder_fec_grouper_top
// RTP reorder buffer releasing packets in sequence order into FEC groups.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    action stream_id rtp_seq packet_len buffer_tag
//  out      output     out_valid / out_stall  kind .. base_seq, last
//  cfg      input      cfg_valid / cfg_ready  cfg_index cfg_data
//
// One item at a time. Every lookup walks the slot memory at one entry per
// cycle. A duplicate check, each drained packet and each closed group take a
// scan pass of their own. An early group closure also runs a serial divider
// to scale the redundancy count. Reset is synchronous. A stalled output holds
// the block only once two results are queued.
module rtp_reorder_fec_grouper_top import rfg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [31:0] stream_id,
  input  logic [15:0] rtp_seq,
  input  logic [15:0] packet_len,
  input  logic [15:0] buffer_tag,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [1:0]  drop_reason,
  output logic [15:0] out_seq,
  output logic [15:0] out_tag,
  output logic [14:0] out_len,
  output logic [6:0]  group_position,
  output logic [6:0]  group_size,
  output logic [6:0]  red_count,
  output logic [14:0] blk_len,
  output logic [15:0] base_seq,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int N = EXT_SEQ_BITS;

  slot_cmd_t  cmd;
  slot_stat_t st;

  rfg_slots u_slots (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (st)
  );

  logic [6:0] gb, grb;
  logic [4:0] mrd;

  state_t state, state_next, scan_ret, scan_ret_next;
  mode_t  mode, mode_next;

  logic [31:0] p_sid;
  logic [15:0] p_seq, p_len, p_tag;

  logic [N-1:0] ext, ext_next;
  logic [1:0]   rsn, rsn_next;
  logic         ev, ev_next, lv, lv_next, mv, mv_next;
  logic [N-1:0] eseq, eseq_next, lseq, lseq_next, mseq, mseq_next;
  logic         known, known_next;
  logic [31:0]  sval, sval_next;
  logic [N-1:0] uw, uw_next;
  logic [6:0]   fill, fill_next;
  logic [14:0]  maxl, maxl_next;
  logic [15:0]  first, first_next;
  logic [13:0]  dv, dv_next;
  logic [6:0]   rem, rem_next;
  logic [3:0]   dcnt, dcnt_next;

  res_t       out_r, hold, hold_fin, e_res;
  logic       out_v, hold_v, e_req, fin_req, e_go, out_free, cap, in_acc;
  logic [6:0] res_cnt;

  logic [15:0]  udelta;
  logic [N-1:0] uext;
  logic [N-1:0] wdiff;
  logic [7:0]   r2;
  logic [6:0]   red_sat;
  state_t       drain_ret;

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_v || !out_stall;
  assign cap       = (res_cnt >= MAX_RESULTS);
  assign e_go      = cap || !hold_v || out_free;

  assign udelta = p_seq - uw[15:0];
  assign uext  = uw + {{(N-16){udelta[15]}}, udelta};
  assign wdiff = lseq - eseq;
  assign r2    = {rem, dv[13]};

  always_comb begin
    if (dv > 14'(RED_MAX))  red_sat = RED_MAX;
    else if (dv == 14'd0)   red_sat = 7'd1;
    else                    red_sat = dv[6:0];
  end

  always_comb begin
    case (mode)
      MODE_FLUSH: drain_ret = S_CLOSE;
      MODE_TFULL: drain_ret = S_AFTER_FULL;
      default:    drain_ret = S_WIN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gb  <= 7'd8;
      grb <= 7'd2;
      mrd <= 5'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_GROUP_BLOCKS: if (cfg_data != 7'd0) gb <= cfg_data;
        CFG_GROUP_RED:    if (cfg_data != 7'd0) grb <= cfg_data;
        CFG_REORDER:      if (cfg_data[4:0] != 5'd0) mrd <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p_sid <= stream_id;
      p_seq <= rtp_seq;
      p_len <= packet_len;
      p_tag <= buffer_tag;
    end
  end

  always_comb begin
    state_next    = state;
    scan_ret_next = scan_ret;
    mode_next     = mode;
    ext_next      = ext;
    rsn_next      = rsn;
    ev_next       = ev;
    lv_next       = lv;
    mv_next       = mv;
    eseq_next     = eseq;
    lseq_next     = lseq;
    mseq_next     = mseq;
    known_next    = known;
    sval_next     = sval;
    uw_next       = uw;
    fill_next     = fill;
    maxl_next     = maxl;
    first_next    = first;
    dv_next       = dv;
    rem_next      = rem;
    dcnt_next     = dcnt;
    cmd           = '0;
    e_req         = 1'b0;
    e_res         = '0;
    fin_req       = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (action) begin
            mode_next  = MODE_FLUSH;
            state_next = S_CLOSE;
          end else begin
            state_next = S_PKT;
          end
        end
      end
      S_PKT: begin
        if (p_len > LEN_LIMIT) begin
          rsn_next   = DROP_OVERSIZE;
          state_next = S_DROP;
        end else if (known && sval != p_sid) begin
          rsn_next   = DROP_STREAM;
          state_next = S_DROP;
        end else begin
          if (!known) begin
            known_next = 1'b1;
            sval_next  = p_sid;
            uw_next    = N'(p_seq);
            ext_next   = N'(p_seq);
          end else begin
            uw_next  = uext;
            ext_next = uext;
          end
          state_next = S_LATE;
        end
      end
      S_LATE: begin
        if (mv && ext < mseq) begin
          rsn_next   = DROP_LATE;
          state_next = S_DROP;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_tgt   = ext;
          scan_ret_next  = S_DUP;
          state_next     = S_SCAN;
        end
      end
      S_DUP: begin
        if (st.found) begin
          rsn_next   = DROP_DUP;
          state_next = S_DROP;
        end else if (st.all_valid) begin
          mode_next  = MODE_TFULL;
          state_next = S_CLOSE;
        end else begin
          state_next = S_INS;
        end
      end
      S_AFTER_FULL: begin
        if (st.all_valid || (mv && ext < mseq)) begin
          rsn_next   = DROP_LATE;
          state_next = S_DROP;
        end else begin
          state_next = S_INS;
        end
      end
      S_INS: begin
        cmd.wr_en       = 1'b1;
        cmd.wr_idx      = st.free_idx;
        cmd.wr_data.seq = ext;
        cmd.wr_data.tag = p_tag;
        cmd.wr_data.len = p_len[14:0];
        if (!lv || lseq < ext) begin
          lseq_next = ext;
          lv_next   = 1'b1;
        end
        mode_next = MODE_WIN;
        if (ev) begin
          state_next = S_DRAIN;
        end else begin
          cmd.scan_start = 1'b1;
          scan_ret_next  = S_EXP;
          state_next     = S_SCAN;
        end
      end
      S_EXP: begin
        eseq_next  = st.min_seq;
        ev_next    = 1'b1;
        state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!ev) begin
          state_next = drain_ret;
        end else begin
          cmd.scan_start = 1'b1;
          cmd.scan_tgt   = eseq;
          scan_ret_next  = S_FOUND;
          state_next     = S_SCAN;
        end
      end
      S_FOUND: begin
        if (!st.found) begin
          state_next = drain_ret;
        end else begin
          e_req     = 1'b1;
          e_res.kind = KIND_PLACED;
          e_res.seq = st.found_entry.seq[15:0];
          e_res.tag = st.found_entry.tag;
          e_res.len = st.found_entry.len;
          e_res.pos = fill;
          if (e_go) begin
            cmd.clr_en  = 1'b1;
            cmd.clr_idx = st.found_idx;
            eseq_next   = eseq + 1'b1;
            mseq_next   = eseq + 1'b1;
            mv_next     = 1'b1;
            if (fill == 7'd0) first_next = st.found_entry.seq[15:0];
            fill_next   = fill + 1'b1;
            if (st.found_entry.len > maxl) maxl_next = st.found_entry.len;
            state_next  = S_CHKFULL;
          end
        end
      end
      S_CHKFULL: begin
        if (fill >= gb) begin
          if (maxl != 15'd0) begin
            state_next = S_FULL_EMIT;
          end else begin
            fill_next      = '0;
            maxl_next      = '0;
            cmd.scan_start = 1'b1;
            scan_ret_next  = S_MAX_DONE;
            state_next     = S_SCAN;
          end
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_FULL_EMIT: begin
        e_req            = 1'b1;
        e_res.kind       = KIND_CLOSED;
        e_res.size       = fill;
        e_res.red        = grb;
        e_res.blk_len    = maxl;
        e_res.base_seq   = first;
        if (e_go) begin
          fill_next      = '0;
          maxl_next      = '0;
          cmd.scan_start = 1'b1;
          scan_ret_next  = S_MAX_DONE;
          state_next     = S_SCAN;
        end
      end
      S_MAX_DONE: begin
        lv_next    = st.any_valid;
        if (st.any_valid) lseq_next = st.max_seq;
        state_next = S_DRAIN;
      end
      S_WIN: begin
        if (st.any_valid && ev && lv && lseq >= eseq && wdiff >= N'(mrd)) begin
          mode_next  = MODE_WIN;
          state_next = S_CLOSE;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CLOSE: begin
        if (fill == 7'd0 || maxl == 15'd0) begin
          // empty group: discard without a closure
          fill_next      = '0;
          maxl_next      = '0;
          cmd.scan_start = 1'b1;
          scan_ret_next  = S_EXT_DONE;
          state_next     = S_SCAN;
        end else begin
          dv_next    = 14'(grb) * 14'(fill);
          rem_next   = '0;
          dcnt_next  = '0;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (r2 >= {1'b0, gb}) begin
          rem_next = 7'(r2 - {1'b0, gb});
          dv_next  = {dv[12:0], 1'b1};
        end else begin
          rem_next = r2[6:0];
          dv_next  = {dv[12:0], 1'b0};
        end
        dcnt_next = dcnt + 1'b1;
        if (dcnt == 4'd13) state_next = S_CLOSE_EMIT;
      end
      S_CLOSE_EMIT: begin
        e_req            = 1'b1;
        e_res.kind       = KIND_CLOSED;
        e_res.size       = fill;
        e_res.red        = red_sat;
        e_res.blk_len    = maxl;
        e_res.base_seq   = first;
        if (e_go) begin
          fill_next      = '0;
          maxl_next      = '0;
          cmd.scan_start = 1'b1;
          scan_ret_next  = S_EXT_DONE;
          state_next     = S_SCAN;
        end
      end
      S_EXT_DONE: begin
        if (!st.any_valid) begin
          state_next = (mode == MODE_FLUSH) ? S_FINISH : drain_ret;
        end else begin
          eseq_next = st.min_seq;
          ev_next   = 1'b1;
          if (mode != MODE_FLUSH) begin
            lseq_next = st.max_seq;
            lv_next   = 1'b1;
          end
          state_next = S_DRAIN;
        end
      end
      S_SCAN: begin
        if (st.done) state_next = scan_ret;
      end
      S_DROP: begin
        e_req             = 1'b1;
        e_res.kind        = KIND_DROPPED;
        e_res.drop_reason = rsn;
        e_res.seq         = p_seq;
        e_res.tag         = p_tag;
        if (e_go) state_next = S_FINISH;
      end
      S_FINISH: begin
        fin_req = 1'b1;
        if (!hold_v || out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      known <= 1'b0;
      sval  <= '0;
      uw    <= '0;
      ev    <= 1'b0;
      lv    <= 1'b0;
      mv    <= 1'b0;
      eseq  <= '0;
      lseq  <= '0;
      mseq  <= '0;
      fill  <= '0;
      maxl  <= '0;
      first <= '0;
    end else begin
      state <= state_next;
      known <= known_next;
      sval  <= sval_next;
      uw    <= uw_next;
      ev    <= ev_next;
      lv    <= lv_next;
      mv    <= mv_next;
      eseq  <= eseq_next;
      lseq  <= lseq_next;
      mseq  <= mseq_next;
      fill  <= fill_next;
      maxl  <= maxl_next;
      first <= first_next;
    end
    scan_ret <= scan_ret_next;
    mode     <= mode_next;
    ext      <= ext_next;
    rsn      <= rsn_next;
    dv       <= dv_next;
    rem      <= rem_next;
    dcnt     <= dcnt_next;
  end

  always_comb begin
    hold_fin      = hold;
    hold_fin.last = 1'b1;
  end

  // hold back one result so the final one of an item can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      out_v   <= 1'b0;
      hold_v  <= 1'b0;
      res_cnt <= '0;
    end else begin
      if (e_req && e_go && !cap && hold_v) begin
        out_r <= hold;
        out_v <= 1'b1;
      end else if (fin_req && hold_v && out_free) begin
        out_r <= hold_fin;
        out_v <= 1'b1;
      end else if (out_v && !out_stall) begin
        out_v <= 1'b0;
      end
      if (e_req && e_go && !cap) begin
        hold   <= e_res;
        hold_v <= 1'b1;
      end else if (fin_req && hold_v && out_free) begin
        hold_v <= 1'b0;
      end
      if (in_acc) begin
        res_cnt <= '0;
      end else if (e_req && e_go && !cap) begin
        res_cnt <= res_cnt + 1'b1;
      end
    end
  end

  assign out_valid      = out_v;
  assign kind           = out_r.kind;
  assign drop_reason    = out_r.drop_reason;
  assign out_seq        = out_r.seq;
  assign out_tag        = out_r.tag;
  assign out_len        = out_r.len;
  assign group_position = out_r.pos;
  assign group_size     = out_r.size;
  assign red_count      = out_r.red;
  assign blk_len        = out_r.blk_len;
  assign base_seq       = out_r.base_seq;
  assign last           = out_r.last;

endmodule

/* dv/rfg_group_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfg_group_checker
// Watches the input, output and register channels of the RTP reorder and FEC
// group former. It keeps its own copy of the reorder table and group state,
// works out the results of each accepted item and compares every accepted
// result with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module rfg_group_checker import rfg_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [31:0] stream_id,
  input  logic [15:0] rtp_seq,
  input  logic [15:0] packet_len,
  input  logic [15:0] buffer_tag,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  kind,
  input  logic [1:0]  drop_reason,
  input  logic [15:0] out_seq,
  input  logic [15:0] out_tag,
  input  logic [14:0] out_len,
  input  logic [6:0]  group_position,
  input  logic [6:0]  group_size,
  input  logic [6:0]  red_count,
  input  logic [14:0] blk_len,
  input  logic [15:0] base_seq,
  input  logic        last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data,
  output int          fail_count,
  output int          pending_results
);

  int          blocks, red_full, depth;
  bit          stream_known;
  logic [31:0] stream_value, unwrap_last;
  bit          exp_ok, latest_ok, floor_ok;
  logic [31:0] exp_seq, latest_seq, floor_seq;
  bit          slot_used [PENDING_SLOTS];
  logic [31:0] slot_seq  [PENDING_SLOTS];
  logic [15:0] slot_tag  [PENDING_SLOTS];
  logic [14:0] slot_len  [PENDING_SLOTS];
  int          fill;
  logic [14:0] fill_max_len;
  logic [15:0] fill_first_seq;

  res_t        expected_results [$];
  int          step_results;
  int          errors;

  function automatic void queue_result(logic [1:0] k, logic [1:0] why, logic [15:0] s,
                                       logic [15:0] t, logic [14:0] l, logic [6:0] p,
                                       logic [6:0] sz, logic [6:0] r, logic [14:0] bs,
                                       logic [15:0] base);
    res_t e;
    e.kind = k; e.drop_reason = why; e.seq = s; e.tag = t; e.len = l; e.pos = p;
    e.size = sz; e.red = r; e.blk_len = bs; e.base_seq = base; e.last = 1'b0;
    if (step_results < MAX_RESULTS)
      expected_results.insert(expected_results.size(), e);
    step_results++;
  endfunction

  function automatic int slot_of(logic [31:0] s);
    for (int i = 0; i < PENDING_SLOTS; i++)
      if (slot_used[i] && slot_seq[i] == s) return i;
    return -1;
  endfunction

  function automatic int slot_extreme(bit want_max);
    int best;
    best = -1;
    for (int i = 0; i < PENDING_SLOTS; i++) begin
      if (!slot_used[i]) continue;
      if (best < 0 || (want_max ? slot_seq[i] > slot_seq[best]
                                : slot_seq[i] < slot_seq[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic void close_group(bit full);
    int r;
    if (fill == 0) return;
    // a group of empty packets goes away silently
    if (fill_max_len != 0) begin
      if (full) begin
        r = red_full;
      end else begin
        r = (red_full * fill) / blocks;
        if (r < 1) r = 1;
        if (r > RED_MAX) r = RED_MAX;
      end
      queue_result(KIND_CLOSED, '0, '0, '0, '0, '0, 7'(fill), 7'(r), fill_max_len,
                   fill_first_seq);
    end
    fill = 0;
    fill_max_len = '0;
  endfunction

  function automatic bit place_slot(int i);
    if (fill == 0) fill_first_seq = slot_seq[i][15:0];
    queue_result(KIND_PLACED, '0, slot_seq[i][15:0], slot_tag[i], slot_len[i], 7'(fill),
                 '0, '0, '0, '0);
    fill++;
    if (slot_len[i] > fill_max_len) fill_max_len = slot_len[i];
    if (fill >= blocks) begin
      close_group(1'b1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void release_in_order();
    int i, hi;
    while (exp_ok) begin
      i = slot_of(exp_seq);
      if (i < 0) break;
      slot_used[i] = 1'b0;
      exp_seq = exp_seq + 1;
      floor_seq = exp_seq;
      floor_ok = 1'b1;
      if (place_slot(i)) begin
        hi = slot_extreme(1'b1);
        latest_ok = hi >= 0;
        if (hi >= 0) latest_seq = slot_seq[hi];
      end
    end
  endfunction

  function automatic bit window_overrun();
    if (slot_extreme(1'b0) < 0 || !exp_ok || !latest_ok) return 1'b0;
    if (latest_seq < exp_seq) return 1'b0;
    return (latest_seq - exp_seq) >= 32'(depth);
  endfunction

  function automatic void skip_hole();
    int lo, hi;
    close_group(1'b0);
    lo = slot_extreme(1'b0);
    hi = slot_extreme(1'b1);
    if (lo < 0 || hi < 0) return;
    exp_seq = slot_seq[lo];
    exp_ok = 1'b1;
    latest_seq = slot_seq[hi];
    latest_ok = 1'b1;
    release_in_order();
  endfunction

  function automatic logic [31:0] extend_seq(logic [15:0] s);
    logic [15:0] d;
    logic [31:0] x;
    d = s - unwrap_last[15:0];
    if (d < 16'h8000) x = unwrap_last + 32'(d);
    else x = unwrap_last - (32'h10000 - 32'(d));
    unwrap_last = x;
    return x;
  endfunction

  function automatic void predict_item(bit flush_req, logic [31:0] sid, logic [15:0] s,
                                       logic [15:0] l, logic [15:0] t);
    logic [31:0] x;
    int i, lo;
    step_results = 0;
    if (flush_req) begin
      forever begin
        close_group(1'b0);
        lo = slot_extreme(1'b0);
        if (lo < 0) break;
        exp_seq = slot_seq[lo];
        exp_ok = 1'b1;
        release_in_order();
      end
    end else if (l > LEN_LIMIT) begin
      queue_result(KIND_DROPPED, DROP_OVERSIZE, s, t, '0, '0, '0, '0, '0, '0);
    end else if (stream_known && stream_value != sid) begin
      queue_result(KIND_DROPPED, DROP_STREAM, s, t, '0, '0, '0, '0, '0, '0);
    end else begin
      if (!stream_known) begin
        stream_known = 1'b1;
        stream_value = sid;
        unwrap_last = 32'(s);
        x = 32'(s);
      end else begin
        x = extend_seq(s);
      end
      if (floor_ok && x < floor_seq) begin
        queue_result(KIND_DROPPED, DROP_LATE, s, t, '0, '0, '0, '0, '0, '0);
      end else if (slot_of(x) >= 0) begin
        queue_result(KIND_DROPPED, DROP_DUP, s, t, '0, '0, '0, '0, '0, '0);
      end else begin
        for (i = 0; i < PENDING_SLOTS && slot_used[i]; i++) ;
        if (i >= PENDING_SLOTS) begin
          skip_hole();
          for (i = 0; i < PENDING_SLOTS && slot_used[i]; i++) ;
        end
        if (i >= PENDING_SLOTS || (floor_ok && x < floor_seq)) begin
          queue_result(KIND_DROPPED, DROP_LATE, s, t, '0, '0, '0, '0, '0, '0);
        end else begin
          slot_used[i] = 1'b1;
          slot_seq[i] = x;
          slot_tag[i] = t;
          slot_len[i] = l[14:0];
          if (!latest_ok || latest_seq < x) begin
            latest_seq = x;
            latest_ok = 1'b1;
          end
          if (!exp_ok) begin
            lo = slot_extreme(1'b0);
            exp_seq = slot_seq[lo < 0 ? i : lo];
            exp_ok = 1'b1;
          end
          release_in_order();
          while (window_overrun()) skip_hole();
        end
      end
    end
    if (step_results > 0)
      expected_results[expected_results.size() - 1].last = 1'b1;
  endfunction

  function automatic void write_reg(logic [1:0] idx, logic [6:0] v);
    case (idx)
      CFG_GROUP_BLOCKS: if (v != 0) blocks = v;
      CFG_GROUP_RED:    if (v != 0) red_full = v;
      CFG_REORDER:      if (v[4:0] != 0) depth = v[4:0];
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      blocks = 8; red_full = 2; depth = 16;
      stream_known = 0; stream_value = '0; unwrap_last = '0;
      exp_ok = 0; latest_ok = 0; floor_ok = 0;
      exp_seq = '0; latest_seq = '0; floor_seq = '0;
      for (int i = 0; i < PENDING_SLOTS; i++) slot_used[i] = 1'b0;
      fill = 0; fill_max_len = '0; fill_first_seq = '0;
      expected_results.delete();
      errors = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing outstanding: kind %0d seq %0d", kind, out_seq);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("kind", e.kind, kind);
          check_field("drop_reason", e.drop_reason, drop_reason);
          check_field("out_seq", e.seq, out_seq);
          check_field("out_tag", e.tag, out_tag);
          check_field("out_len", e.len, out_len);
          check_field("group_position", e.pos, group_position);
          check_field("group_size", e.size, group_size);
          check_field("red_count", e.red, red_count);
          check_field("blk_len", e.blk_len, blk_len);
          check_field("base_seq", e.base_seq, base_seq);
          check_field("last", e.last, last);
        end
      end
      if (in_valid && !in_stall)
        predict_item(action, stream_id, rtp_seq, packet_len, buffer_tag);
      if (cfg_valid && cfg_ready)
        write_reg(cfg_index, cfg_data);
    end
    fail_count      <= errors;
    pending_results <= expected_results.size();
  end

endmodule

/* dv/rtp_reorder_fec_grouper_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtp_reorder_fec_grouper_top_tb
// Drives packet descriptors and flushes into the reorder and FEC group former
// under several register settings, with random gaps and output stalls; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module rtp_reorder_fec_grouper_top_tb import rfg_pkg::*;;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES  = 3000;

  logic        clk;
  logic        rst;
  logic        in_valid, in_stall, action;
  logic [31:0] stream_id;
  logic [15:0] rtp_seq, packet_len, buffer_tag;
  logic        out_valid, out_stall;
  logic [1:0]  kind, drop_reason;
  logic [15:0] out_seq, out_tag, base_seq;
  logic [14:0] out_len, blk_len;
  logic [6:0]  group_position, group_size, red_count;
  logic        last;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [6:0]  cfg_data;
  int          fail_count, pending_results;

  bit          idle_on;
  int          stall_free;
  logic [31:0] our_stream;
  logic [15:0] next_seq;

  rtp_reorder_fec_grouper_top i_dut (.*);
  rfg_group_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // output stalls in bursts while idling is on
  initial begin
    out_stall = 1'b0;
    forever begin
      if (!idle_on) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      stall_free <= 0;
    else
      stall_free <= stall_free + 1;
    if (stall_free == WATCHDOG_LIMIT) begin
      $display("rtp_reorder_fec_grouper_top_tb NOT OK");
      $finish;
    end
  end

  task automatic send(bit flush_req, logic [31:0] sid, logic [15:0] s, logic [15:0] l,
                      logic [15:0] t);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    action     <= flush_req;
    stream_id  <= sid;
    rtp_seq    <= s;
    packet_len <= l;
    buffer_tag <= t;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_pkt(logic [15:0] s, logic [15:0] l);
    send(1'b0, our_stream, s, l, 16'($urandom));
  endtask

  task automatic send_flush();
    send(1'b1, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // hold until every result is out, then let the block finish any tail work
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] rand_len();
    case ($urandom_range(0, 9))
      0, 1: return 16'd0;
      2:    return 16'($urandom_range(32768, 65535));
      3:    return 16'd32767;
      default: return 16'($urandom_range(0, 32767));
    endcase
  endfunction

  // a run of consecutive sequences in shuffled order, sometimes with a hole or noise
  task automatic send_run(ref int sent);
    logic [15:0] run [16];
    logic [15:0] tmp;
    int n, j, hole;
    n = $urandom_range(2, 12);
    for (int i = 0; i < n; i++) run[i] = next_seq + 16'(i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = run[i]; run[i] = run[j]; run[j] = tmp;
    end
    hole = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
    for (int i = 0; i < n; i++) begin
      if (i != hole) begin
        send_pkt(run[i], rand_len());
        sent++;
      end
      case ($urandom_range(0, 19))
        0: send_pkt(run[i], 16'($urandom_range(0, 32767)));
        1: send_pkt(next_seq - 16'($urandom_range(1, 300)), rand_len());
        2: send(1'b0, our_stream ^ ($urandom | 32'd1), 16'($urandom), rand_len(),
                16'($urandom));
        3: send_pkt(16'($urandom), 16'($urandom_range(32768, 65535)));
        default: ;
      endcase
    end
    next_seq += 16'(n);
    case ($urandom_range(0, 9))
      0: send_flush();
      1: next_seq += 16'($urandom_range(2, 40));
      2: next_seq += 16'($urandom);
      default: ;
    endcase
  endtask

  task automatic random_phase(int items, bit pause_midway);
    int sent;
    bit paused;
    sent = 0;
    paused = 0;
    while (sent < items) begin
      send_run(sent);
      if (pause_midway && !paused && sent > items / 2) begin
        paused = 1;
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
      end
    end
    send_flush();
    settle();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0; action = 1'b0; stream_id = '0;
    rtp_seq = '0; packet_len = '0; buffer_tag = '0;
    cfg_valid = 1'b0; cfg_index = CFG_GROUP_BLOCKS; cfg_data = '0;
    idle_on = 1'b1;
    our_stream = $urandom;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with the reset settings
    send_flush();
    send(1'b0, our_stream, 16'd65530, 16'd0, 16'hFFFF);
    send(1'b0, our_stream, 16'd65532, 16'd32767, 16'h0000);
    send_pkt(16'd65531, 16'd5);
    send_pkt(16'd65533, 16'hFFFF);
    send_pkt(16'd65533, 16'd32768);
    send(1'b0, ~our_stream, 16'd65533, 16'd10, 16'h5A5A);
    send_pkt(16'd1, 16'd200);
    send_pkt(16'd1, 16'd201);
    send_pkt(16'd65529, 16'd7);
    // far ahead of the hole: the window gives up and skips it
    send_pkt(16'd20, 16'd300);
    for (int s = 22; s <= 27; s++) send_pkt(16'(s), 16'($urandom_range(0, 32767)));
    send_flush();
    send_pkt(16'd28, 16'd0);
    send_pkt(16'd29, 16'd0);
    send_flush();
    send_pkt(16'd40028, 16'd9);
    settle();
    next_seq = 16'd30;

    // register writes of zero are ignored
    write_reg(CFG_GROUP_BLOCKS, 7'd0);
    write_reg(CFG_GROUP_RED, 7'd0);
    write_reg(CFG_REORDER, 7'd32);
    write_reg(CFG_GROUP_BLOCKS, 7'd1);
    write_reg(CFG_GROUP_RED, 7'd127);
    write_reg(CFG_REORDER, 7'd1);
    random_phase(25, 1'b0);

    write_reg(CFG_GROUP_BLOCKS, 7'd127);
    write_reg(CFG_REORDER, 7'd31);
    random_phase(25, 1'b1);

    // open a large group, then shrink the group size beneath it
    write_reg(CFG_GROUP_BLOCKS, 7'd60);
    write_reg(CFG_REORDER, 7'd20);
    for (int i = 0; i < 10; i++) send_pkt(next_seq + 16'(i), 16'($urandom_range(1, 32767)));
    next_seq += 16'd10;
    settle();
    write_reg(CFG_GROUP_BLOCKS, 7'd3);
    send_flush();
    settle();
    write_reg(CFG_GROUP_RED, 7'($urandom_range(1, 127)));
    write_reg(CFG_REORDER, 7'($urandom_range(1, 31)));
    random_phase(25, 1'b0);

    idle_on = 1'b0;
    write_reg(CFG_GROUP_BLOCKS, 7'($urandom_range(1, 16)));
    write_reg(CFG_GROUP_RED, 7'($urandom_range(1, 8)));
    write_reg(CFG_REORDER, 7'($urandom_range(4, 31)));
    random_phase(25, 1'b0);

    if (fail_count == 0)
      $display("rtp_reorder_fec_grouper_top_tb OK");
    else
      $display("rtp_reorder_fec_grouper_top_tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rfg_pkg.sv
hw/rtl/rfg_slots.sv
hw/rtl/rtp_reorder_fec_grouper_top.sv
dv/rfg_group_checker.sv
dv/rtp_reorder_fec_grouper_top_tb.sv
